@@ rtl/negatable_max_queue_unit_assert.svh @@
// Assertion macros for the negatable max queue unit.
// Used by the top level; expects clk and rst in scope.
`ifndef NEGATABLE_MAX_QUEUE_UNIT_ASSERT_SVH
`define NEGATABLE_MAX_QUEUE_UNIT_ASSERT_SVH

// Same-cycle implication, disabled during reset
`define NMQ_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("nmq assertion failed");

// Next-cycle implication, disabled during reset
`define NMQ_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("nmq assertion failed");

`endif

@@ rtl/nmq_pkg.sv @@
// Shared types, constants and command codes for the negatable max queue.
// No dependencies.
package nmq_pkg;

  localparam int QUEUE_DEPTH_DEF = 64;

  typedef logic signed [15:0] value_t;
  typedef logic signed [16:0] max_t;
  typedef logic [2:0]         func_t;

  localparam value_t VAL_MIN = 16'sh8000;
  localparam value_t VAL_MAX = 16'sh7fff;

  // command codes
  localparam func_t FUNC_ENQ   = 3'd0;
  localparam func_t FUNC_DEQ   = 3'd1;
  localparam func_t FUNC_NEG   = 3'd2;
  localparam func_t FUNC_QUERY = 3'd3;
  localparam func_t FUNC_CLEAR = 3'd4;

  // per-cell control from the queue controller
  typedef struct packed {
    logic load;
    logic shift;
    logic clear;
  } cell_ctl_t;

endpackage

@@ rtl/nmq_channels.sv @@
// Valid/ready channel interfaces for the negatable max queue.
// Depends on nmq_pkg.
interface nmq_in_if import nmq_pkg::*; ();
  logic   valid;
  logic   ready;
  func_t  func;
  value_t value;

  modport source (output valid, output func, output value, input ready);
  modport sink   (input valid, input func, input value, output ready);
endinterface

interface nmq_out_if import nmq_pkg::*; ();
  logic valid;
  logic ready;
  max_t max_value;

  modport source (output valid, output max_value, input ready);
  modport sink   (input valid, input max_value, output ready);
endinterface

@@ rtl/nmq_cell.sv @@
// One queue cell: holds a raw value and valid bit, shifts toward the head,
// and keeps a registered running max/min of itself and the cells behind it.
// Depends on nmq_pkg.
module nmq_cell import nmq_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  cell_ctl_t ctl,
  input  value_t    wr_value,
  input  value_t    nbr_value,
  input  logic      nbr_valid,
  input  value_t    nbr_max,
  input  value_t    nbr_min,
  output value_t    value,
  output logic      valid,
  output value_t    agg_max,
  output value_t    agg_min
);

  // stored value: written on enqueue, taken from the neighbor on dequeue
  always_ff @(posedge clk) begin
    if (ctl.load) begin
      value <= wr_value;
    end else if (ctl.shift) begin
      value <= nbr_value;
    end
  end

  // valid bit
  always_ff @(posedge clk) begin
    if (rst || ctl.clear) begin
      valid <= 1'b0;
    end else if (ctl.load) begin
      valid <= 1'b1;
    end else if (ctl.shift) begin
      valid <= nbr_valid;
    end
  end

  // suffix max/min, one cell per cycle toward the head
  always_ff @(posedge clk) begin
    agg_max <= (valid && (value > nbr_max)) ? value : nbr_max;
    agg_min <= (valid && (value < nbr_min)) ? value : nbr_min;
  end

endmodule

@@ rtl/negatable_max_queue_unit.sv @@
// Negatable max queue: a FIFO of signed 16-bit words with negate-all and
// max query. Input channel in_ch carries func and value; output channel
// out_ch carries max_value, one word per maximum query on a nonempty queue.
// Enqueue, dequeue, negate, clear and ignored codes may follow back to back.
// Values live in a row of QUEUE_DEPTH cells that shift toward the head on
// dequeue; each cell registers the max/min of itself and the cells behind
// it, so a change passes cell by cell toward the head. A query waits until
// the settle counter, reloaded by each enqueue, dequeue or clear, has run
// down to zero, then loads the output register; in_ch.ready is low while
// the query is pending.
// Negation is a sign flag; the result is the negated minimum when it is set.
// The output register holds a word until out_ch.ready; other commands are
// still taken while it waits. Reset (rst, synchronous) empties the queue,
// clears the flag and drops any pending word; no clearing pass is needed.
// Depends on nmq_pkg, nmq_channels, nmq_cell and the assertion header.
`include "negatable_max_queue_unit_assert.svh"

module negatable_max_queue_unit import nmq_pkg::*; #(
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
  input logic      clk,
  input logic      rst,
  nmq_in_if.sink   in_ch,
  nmq_out_if.source out_ch
);

  localparam int CW = $clog2(QUEUE_DEPTH + 1);

  logic [CW-1:0] count;
  logic [CW-1:0] settle;
  logic          negated;
  logic          pend;
  logic          out_valid;
  max_t          out_max;

  value_t    cell_value [QUEUE_DEPTH];
  logic      cell_valid [QUEUE_DEPTH];
  value_t    cell_max   [QUEUE_DEPTH];
  value_t    cell_min   [QUEUE_DEPTH];

  logic   in_fire;
  logic   do_enq;
  logic   do_deq;
  logic   do_neg;
  logic   do_query;
  logic   do_clear;
  logic   is_empty;
  logic   is_full;
  logic   load_out;
  value_t wr_raw;

  assign in_ch.ready  = !pend;
  assign in_fire      = in_ch.valid && in_ch.ready;
  assign is_empty     = (count == '0);
  assign is_full      = (count == CW'(QUEUE_DEPTH));

  // command decode
  always_comb begin
    do_enq   = 1'b0;
    do_deq   = 1'b0;
    do_neg   = 1'b0;
    do_query = 1'b0;
    do_clear = 1'b0;
    if (in_fire) begin
      case (in_ch.func)
        FUNC_ENQ:   do_enq   = !is_full;
        FUNC_DEQ:   do_deq   = !is_empty;
        FUNC_NEG:   do_neg   = 1'b1;
        FUNC_QUERY: do_query = !is_empty;
        FUNC_CLEAR: do_clear = 1'b1;
        default:    ;
      endcase
    end
  end

  // raw value to store; flag counts as clear when the queue is empty
  always_comb begin
    if (negated && !is_empty) begin
      wr_raw = (in_ch.value == VAL_MIN) ? VAL_MAX : -in_ch.value;
    end else begin
      wr_raw = in_ch.value;
    end
  end

  // cell row
  for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
    cell_ctl_t ctl;
    value_t    nv;
    logic      nvld;
    value_t    nmax;
    value_t    nmin;

    assign ctl.load  = do_enq && (count == CW'(i));
    assign ctl.shift = do_deq;
    assign ctl.clear = do_clear;

    if (i == QUEUE_DEPTH - 1) begin : g_tail
      assign nv   = VAL_MAX;
      assign nvld = 1'b0;
      assign nmax = VAL_MIN;
      assign nmin = VAL_MAX;
    end else begin : g_mid
      assign nv   = cell_value[i+1];
      assign nvld = cell_valid[i+1];
      assign nmax = cell_max[i+1];
      assign nmin = cell_min[i+1];
    end

    nmq_cell u_cell (
      .clk       (clk),
      .rst       (rst),
      .ctl       (ctl),
      .wr_value  (wr_raw),
      .nbr_value (nv),
      .nbr_valid (nvld),
      .nbr_max   (nmax),
      .nbr_min   (nmin),
      .value     (cell_value[i]),
      .valid     (cell_valid[i]),
      .agg_max   (cell_max[i]),
      .agg_min   (cell_min[i])
    );
  end

  // occupancy count
  always_ff @(posedge clk) begin
    if (rst || do_clear) begin
      count <= '0;
    end else if (do_enq) begin
      count <= count + 1'b1;
    end else if (do_deq) begin
      count <= count - 1'b1;
    end
  end

  // cycles until the head aggregate is exact again
  always_ff @(posedge clk) begin
    if (rst) begin
      settle <= '0;
    end else if (do_enq || do_deq || do_clear) begin
      settle <= CW'(QUEUE_DEPTH);
    end else if (settle != '0) begin
      settle <= settle - 1'b1;
    end
  end

  // negate flag
  always_ff @(posedge clk) begin
    if (rst || do_clear) begin
      negated <= 1'b0;
    end else if (do_enq && is_empty) begin
      negated <= 1'b0;
    end else if (do_neg) begin
      negated <= !negated;
    end
  end

  // pending query and output register
  assign load_out = pend && (settle == '0) && (!out_valid || out_ch.ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      pend <= 1'b0;
    end else if (do_query) begin
      pend <= 1'b1;
    end else if (load_out) begin
      pend <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_out) begin
      out_valid <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_max <= negated ? -max_t'(cell_min[0]) : max_t'(cell_max[0]);
    end
  end

  assign out_ch.valid     = out_valid;
  assign out_ch.max_value = out_max;

  // checks
  `NMQ_ASSERT_IMPL(a_count_bound, 1'b1, count <= CW'(QUEUE_DEPTH))
  `NMQ_ASSERT_IMPL(a_head_valid, 1'b1, cell_valid[0] == (count != '0))
  `NMQ_ASSERT_IMPL(a_pend_blocks, pend, !in_ch.ready)
  `NMQ_ASSERT_NEXT(a_deq_count, do_deq, count == $past(count) - 1'b1)

endmodule
